[design/assert_macros.svh]
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/slmcs_pkg.sv]
// types and constants for the scrolling led matrix column scanner
package slmcs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;
  localparam int COL_W      = 3;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_LEN   = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [BYTE_W-1:0] COL_DRIVE_MSB = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_ONES     = 8'hff;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

[design/slmcs_store.sv]
// animation store: one write port, one registered read port
module slmcs_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [slmcs_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [slmcs_pkg::BYTE_W-1:0] rdata
);
  import slmcs_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/slmcs_mod.sv]
// bit-serial remainder unit, one dividend bit per cycle
module slmcs_mod #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [AW:0]   divisor,
  output logic          done,
  output logic [AW-1:0] rem
);
  import slmcs_pkg::*;

  localparam int CW = $clog2(AW + 1);

  logic [AW-1:0] shreg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [AW:0]   trial;

  assign trial = {rem, shreg[AW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(AW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (trial >= divisor) begin
        rem <= AW'(trial - divisor);
      end else begin
        rem <= AW'(trial);
      end
    end
  end

endmodule

[design/scrolling_led_matrix_column_scan_top.sv]
// top level of the scrolling led matrix column scanner
//
// input stream s_*: tuser is the op (0 store write, 1 frame tick); tdata carries
// entry_index and entry_data for store writes. configuration is written on
// cfg_we with cfg_index selecting column_count, speed, offset_step or the
// scroll length; the user must write it only while the block is idle, which
// the block itself does not enforce. output stream m_*: one transaction per
// scanned column with column_index, column_drive and row_data in tdata and
// tlast on the final column. a frame tick first reduces the scroll offset
// modulo the scroll length in a bit-serial unit (one bit per cycle), then
// emits one column per cycle from the store read port while the receiver
// does not stall, then advances the frame counter in an update state and,
// once the counter passes speed, the offset. the first column follows once
// the remainder is done and its store read is registered. s_tready is high
// only between items; a finished column waits in the output register, so the
// next item is taken while the last column waits. a receiver stall holds the
// output register and pauses the scan. reset (rst, synchronous) restores the
// state, configuration and output valid to their defaults and clears frame
// counter and offset; store contents stay undefined until written.
module scrolling_led_matrix_column_scan_top #(
  parameter int MAX_ENTRIES = 64,
  parameter int NUM_COLUMNS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // entry_index [5:0], entry_data [13:6], zero pad [15:14]
  input  logic [slmcs_pkg::S_TDATA_W-1:0]    s_tdata,
  // op
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // column_index [2:0], column_drive [10:3], row_data [18:11], zero pad [23:19]
  output logic [slmcs_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [slmcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slmcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import slmcs_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int LW = AW + 1;
  localparam int SW = ((AW > 6) ? AW : 6) + 1;

  state_t state, state_next;

  logic [3:0]        column_count;
  logic [7:0]        speed;
  logic [5:0]        offset_step;
  logic [6:0]        scroll_len;

  logic [7:0]        frame_counter;
  logic [AW-1:0]     scroll_offset;
  logic [AW-1:0]     pos, pos_next;
  logic [COL_W-1:0]  col;

  logic              out_valid;
  logic [COL_W-1:0]  out_col;
  logic [BYTE_W-1:0] out_drive;
  logic [BYTE_W-1:0] out_row;
  logic              out_last;

  logic [LW-1:0]     len_eff;
  logic [3:0]        n_eff;
  logic              col_last;
  logic [LW-1:0]     pos_inc;
  logic [SW-1:0]     offset_sum;
  logic [8:0]        count_inc;

  logic              in_accept;
  logic              tick_accept;
  logic              out_last_exp;
  logic              mod_start;
  logic              mod_done;
  logic [AW-1:0]     mod_rem;
  logic              load;
  logic              store_we;
  logic [BYTE_W-1:0] rdata;

  assign len_eff = (scroll_len == 7'd0) ? LW'(1) :
                   (32'(scroll_len) > MAX_ENTRIES) ? LW'(MAX_ENTRIES) :
                   LW'(scroll_len);
  assign n_eff      = (32'(column_count) > NUM_COLUMNS) ? 4'(NUM_COLUMNS) : column_count;
  assign col_last   = ({1'b0, col} + 4'd1) == n_eff;
  assign pos_inc    = {1'b0, pos} + LW'(1);
  assign offset_sum = SW'(scroll_offset) + SW'(offset_step);
  assign count_inc  = {1'b0, frame_counter} + 9'd1;

  assign in_accept    = s_tvalid && s_tready;
  assign tick_accept  = in_accept && (s_tuser == OP_TICK);
  assign out_last_exp = ({1'b0, out_col} + 4'd1) == n_eff;
  assign store_we  = in_accept && (s_tuser == OP_WRITE) && (32'(s_tdata[5:0]) < MAX_ENTRIES);

  slmcs_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(s_tdata[5:0])),
    .wdata (s_tdata[13:6]),
    .raddr (pos_next),
    .rdata (rdata)
  );

  slmcs_mod #(
    .AW (AW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (scroll_offset),
    .divisor  (len_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mod_start  = 1'b0;
    load       = 1'b0;
    pos_next   = pos;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && (s_tuser == OP_TICK)) begin
          mod_start  = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          pos_next   = mod_rem;
          state_next = (n_eff == 4'd0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!out_valid || m_tready) begin
          load     = 1'b1;
          pos_next = (pos_inc == len_eff) ? '0 : AW'(pos_inc);
          if (col_last) begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 4'd8;
      speed        <= 8'd0;
      offset_step  <= 6'd1;
      scroll_len   <= 7'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMN_COUNT: column_count <= cfg_data[3:0];
        CFG_SPEED:        speed        <= cfg_data;
        CFG_OFFSET_STEP:  offset_step  <= cfg_data[5:0];
        CFG_SCROLL_LEN:   scroll_len   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
      scroll_offset <= '0;
    end else if (state == ST_UPDATE) begin
      if (count_inc > {1'b0, speed}) begin
        frame_counter <= '0;
        scroll_offset <= (offset_sum >= SW'(len_eff)) ? '0 : AW'(offset_sum);
      end else begin
        frame_counter <= count_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (state == ST_MOD) begin
      col <= '0;
    end else if (load) begin
      col <= col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_col   <= col;
      out_drive <= (COL_DRIVE_MSB >> col) ^ BYTE_ONES;
      out_row   <= rdata;
      out_last  <= col_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'd0, out_row, out_drive, out_col};

  `ASSERT_SAME(a_pos_in_range, state == ST_SCAN, {1'b0, pos} < len_eff, "scan beyond length")
  `ASSERT_SAME(a_mod_done_state, mod_done, state == ST_MOD, "remainder done outside mod phase")
  `ASSERT_SAME(a_last_matches, out_valid, out_last_exp == out_last, "tlast mismatch")
  `ASSERT_NEXT(a_tick_starts_mod, tick_accept, state == ST_MOD && !s_tready, "tick not started")

endmodule
